// File: src/i3dq_pkg.sv
// Shared types, constants and helpers for the int3 dequantizing dot-product unit.
// No dependencies.
package i3dq_pkg;

  localparam int MAX_ROW_LENGTH = 4096;
  localparam int MAX_ROWS       = 4096;

  localparam int CFG_W  = 13;
  localparam int IDX_W  = 12;
  localparam int CODE_W = 3;
  localparam int ACT_W  = 16;
  localparam int SCL_W  = 16;
  localparam int P1_W   = 19;
  localparam int PROD_W = 35;
  localparam int ACC_W  = 48;

  localparam logic [CFG_W-1:0] ROW_LENGTH_RST = CFG_W'(MAX_ROW_LENGTH);
  localparam logic [CFG_W-1:0] GROUP_SIZE_RST = CFG_W'(32);
  localparam logic [CFG_W-1:0] ROW_COUNT_RST  = CFG_W'(MAX_ROWS);

  localparam logic signed [3:0] LEVEL_OFFSET = 4'sd4;

  typedef enum logic [1:0] {
    REG_ROW_LENGTH = 2'd0,
    REG_GROUP_SIZE = 2'd1,
    REG_ROW_COUNT  = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL_LEVEL,
    ST_MUL_SCALE,
    ST_ACCUM
  } state_t;

  typedef struct packed {
    logic take;
    logic mul_level;
    logic mul_scale;
    logic accum;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } status_t;

  function automatic logic [CFG_W-1:0] clamp_reg(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: src/i3dq_ctrl.sv
// Sequencer for the dot-product unit: steps one item through the two multiplies
// and the accumulate. Depends on i3dq_pkg.
module i3dq_ctrl import i3dq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MUL_LEVEL;
      end
      ST_MUL_LEVEL: state_next = ST_MUL_SCALE;
      ST_MUL_SCALE: state_next = ST_ACCUM;
      ST_ACCUM: begin
        if (!(status.last && status.out_busy)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_MUL_LEVEL: cmd.mul_level = 1'b1;
      ST_MUL_SCALE: cmd.mul_scale = 1'b1;
      ST_ACCUM:     cmd.accum = !(status.last && status.out_busy);
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: src/i3dq_datapath.sv
// Datapath: configuration registers, row/group counters, scale hold, two multiplies,
// saturating accumulator and result register. Depends on i3dq_pkg.
module i3dq_datapath import i3dq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic [CODE_W-1:0]       weight_code,
  input  logic signed [ACT_W-1:0] activation,
  input  logic [SCL_W-1:0]        scale,
  input  cmd_t                    cmd,
  output status_t                 status,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [ACC_W-1:0] row_result,
  output logic [IDX_W-1:0]        row_number
);

  logic [CFG_W-1:0] row_length;
  logic [CFG_W-1:0] group_size;
  logic [CFG_W-1:0] row_count;

  logic signed [ACC_W-1:0]  accumulator;
  logic [IDX_W-1:0]         element_index;
  logic [IDX_W-1:0]         group_position;
  logic [SCL_W-1:0]         held_scale;
  logic [IDX_W-1:0]         current_row;

  logic [CODE_W-1:0]        code_q;
  logic signed [ACT_W-1:0]  act_q;
  logic signed [P1_W-1:0]   p1;
  logic signed [PROD_W-1:0] prod;
  logic                     last_q;
  logic [IDX_W-1:0]         row_q;

  logic [CFG_W-1:0] len;
  logic [CFG_W-1:0] gsz;
  logic [CFG_W-1:0] rows;
  logic             new_group;
  logic [CFG_W-1:0] gpos_inc;
  logic [CFG_W-1:0] eidx_inc;
  logic [CFG_W-1:0] row_inc;
  logic             last;
  logic [IDX_W-1:0] gpos_next;
  logic [IDX_W-1:0] row_next;

  logic signed [3:0]        level;
  logic signed [P1_W-1:0]   lvl_x;
  logic signed [P1_W-1:0]   act_x;
  logic signed [PROD_W-1:0] p1_x;
  logic signed [PROD_W-1:0] scl_x;
  logic signed [ACC_W:0]    sum;
  logic signed [ACC_W-1:0]  sum_sat;

  assign len  = clamp_reg(row_length, CFG_W'(MAX_ROW_LENGTH));
  assign gsz  = clamp_reg(group_size, CFG_W'(MAX_ROW_LENGTH));
  assign rows = clamp_reg(row_count, CFG_W'(MAX_ROWS));

  assign new_group = (group_position == '0) || ({1'b0, group_position} >= gsz);
  assign gpos_inc  = new_group ? CFG_W'(1) : {1'b0, group_position} + CFG_W'(1);
  assign eidx_inc  = {1'b0, element_index} + CFG_W'(1);
  assign row_inc   = {1'b0, current_row} + CFG_W'(1);
  assign last      = eidx_inc >= len;

  always_comb begin
    if (last || gpos_inc >= gsz) begin
      gpos_next = '0;
    end else begin
      gpos_next = gpos_inc[IDX_W-1:0];
    end
    if (!last) begin
      row_next = current_row;
    end else if (row_inc >= rows) begin
      row_next = '0;
    end else begin
      row_next = row_inc[IDX_W-1:0];
    end
  end

  assign level = $signed({1'b0, code_q}) - LEVEL_OFFSET;
  assign lvl_x = P1_W'(level);
  assign act_x = P1_W'(act_q);
  assign p1_x  = PROD_W'(p1);
  assign scl_x = PROD_W'($signed({1'b0, held_scale}));

  assign sum = (ACC_W+1)'(accumulator) + (ACC_W+1)'(prod);

  always_comb begin
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      sum_sat = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sum_sat = sum[ACC_W-1:0];
    end
  end

  assign status.last     = last_q;
  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= ROW_LENGTH_RST;
      group_size <= GROUP_SIZE_RST;
      row_count  <= ROW_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_LENGTH: row_length <= cfg_data;
        REG_GROUP_SIZE: group_size <= cfg_data;
        REG_ROW_COUNT:  row_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_index  <= '0;
      group_position <= '0;
      held_scale     <= '0;
      current_row    <= '0;
      accumulator    <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.take) begin
        if (new_group) held_scale <= scale;
        group_position <= gpos_next;
        element_index  <= last ? '0 : eidx_inc[IDX_W-1:0];
        current_row    <= row_next;
      end
      if (cmd.accum && last_q) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.accum) begin
        if (last_q) begin
          accumulator <= '0;
        end else begin
          accumulator <= sum_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      code_q <= weight_code;
      act_q  <= activation;
      last_q <= last;
      row_q  <= current_row;
    end
    if (cmd.mul_level) p1 <= lvl_x * act_x;
    if (cmd.mul_scale) prod <= p1_x * scl_x;
    if (cmd.accum && last_q) begin
      row_result <= sum_sat;
      row_number <= row_q;
    end
  end

endmodule

// File: src/int3_dequant_dot_product_unit.sv
// Top level of the int3 group-quantized dot-product unit: sequencer plus datapath.
// Depends on i3dq_pkg, i3dq_ctrl and i3dq_datapath.
//
// Each weight element passes in turn through transfer in, level times activation,
// product times the held group scale, then a saturating 48-bit accumulate. The two
// chained multiplies and the accumulate each own one register stage, and the unit
// holds one element at a time. Row results sit in an output register, so the next
// element is taken while a row result waits; a row-ending element stays in its
// accumulate step until that register has been emptied. Configuration writes are
// single-cycle on cfg_we and take effect for the next element.
module int3_dequant_dot_product_unit import i3dq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CODE_W-1:0]       weight_code,
  input  logic signed [ACT_W-1:0] activation,
  input  logic [SCL_W-1:0]        scale,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [ACC_W-1:0] row_result,
  output logic [IDX_W-1:0]        row_number
);

  cmd_t    cmd;
  status_t status;

  i3dq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  i3dq_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .weight_code (weight_code),
    .activation  (activation),
    .scale       (scale),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .row_result  (row_result),
    .row_number  (row_number)
  );

endmodule

// File: tb/sv/tb_int3_dequant_dot_product_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for int3_dequant_dot_product_unit: directed table, then random
// phases, with an in-bench row accumulator predictor. Depends on i3dq_pkg and the unit.
module tb_int3_dequant_dot_product_unit import i3dq_pkg::*;;

  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 400;
  localparam int STALL_LIMIT    = 4000;
  localparam int RAND_ELEMS     = 600;
  localparam int PHASES         = 10;
  localparam int PHASE_ELEMS    = RAND_ELEMS / PHASES;
  localparam int PRESSURE_PHASE = 3;
  localparam longint ACC_TOP    = (longint'(1) << (ACC_W - 1)) - 1;
  localparam logic [1:0] REG_NONE = 2'd3;

  typedef enum logic {STEP_CFG, STEP_ELEM} step_kind_t;
  typedef enum int {SINK_OPEN, SINK_HALF, SINK_SPARSE, SINK_EVERY_THIRD} sink_mode_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] sum;
    logic [IDX_W-1:0]        row;
  } row_sum_t;

  typedef struct packed {
    step_kind_t              kind;
    logic [1:0]              idx;
    logic [CFG_W-1:0]        data;
    logic [CODE_W-1:0]       code;
    logic signed [ACT_W-1:0] act;
    logic [SCL_W-1:0]        scl;
    logic                    known;
    logic signed [ACC_W-1:0] sum;
    logic [IDX_W-1:0]        row;
  } step_t;

  localparam int PLAN_LEN = 30;
  localparam step_t PLAN [PLAN_LEN] = '{
    '{STEP_CFG,  REG_ROW_LENGTH, 13'd1,    3'd0, 16'sd0,    16'd0,     1'b0, 48'sd0, 12'd0},
    '{STEP_CFG,  REG_ROW_COUNT,  13'd3,    3'd0, 16'sd0,    16'd0,     1'b0, 48'sd0, 12'd0},
    '{STEP_ELEM, 2'd0, 13'd0, 3'd0, 16'sh8000, 16'hffff, 1'b1, 48'sd8589803520, 12'd0},
    '{STEP_ELEM, 2'd0, 13'd0, 3'd7, 16'sh8000, 16'hffff, 1'b1, -48'sd6442352640, 12'd1},
    '{STEP_ELEM, 2'd0, 13'd0, 3'd4, 16'sh7fff, 16'hffff, 1'b1, 48'sd0, 12'd2},
    '{STEP_ELEM, 2'd0, 13'd0, 3'd0, 16'sh7fff, 16'hffff, 1'b1, -48'sd8589541380, 12'd0},
    '{STEP_ELEM, 2'd0, 13'd0, 3'd3, 16'sd1,    16'd0,     1'b1, 48'sd0, 12'd1},
    '{STEP_ELEM, 2'd0, 13'd0, 3'd5, 16'sd1,    16'd1,     1'b1, 48'sd1, 12'd2},
    '{STEP_CFG,  REG_ROW_LENGTH, 13'd0,    3'd0, 16'sd0,    16'd0,     1'b0, 48'sd0, 12'd0},
    '{STEP_CFG,  REG_ROW_COUNT,  13'd0,    3'd0, 16'sd0,    16'd0,     1'b0, 48'sd0, 12'd0},
    '{STEP_ELEM, 2'd0, 13'd0, 3'd6, -16'sd1,   16'd2,     1'b1, -48'sd4, 12'd0},
    '{STEP_ELEM, 2'd0, 13'd0, 3'd1, 16'sd256,  16'd4096,  1'b1, -48'sd3145728, 12'd0},
    '{STEP_CFG,  REG_NONE,       13'd5,    3'd0, 16'sd0,    16'd0,     1'b0, 48'sd0, 12'd0},
    '{STEP_ELEM, 2'd0, 13'd0, 3'd7, 16'sd100,  16'd10,    1'b1, 48'sd3000, 12'd0},
    '{STEP_CFG,  REG_ROW_LENGTH, 13'd3,    3'd0, 16'sd0,    16'd0,     1'b0, 48'sd0, 12'd0},
    '{STEP_CFG,  REG_GROUP_SIZE, 13'd2,    3'd0, 16'sd0,    16'd0,     1'b0, 48'sd0, 12'd0},
    '{STEP_CFG,  REG_ROW_COUNT,  13'd8191, 3'd0, 16'sd0,    16'd0,     1'b0, 48'sd0, 12'd0},
    '{STEP_ELEM, 2'd0, 13'd0, 3'd5, 16'sd2,    16'd3,     1'b0, 48'sd0, 12'd0},
    '{STEP_ELEM, 2'd0, 13'd0, 3'd5, 16'sd2,    16'd999,   1'b0, 48'sd0, 12'd0},
    '{STEP_ELEM, 2'd0, 13'd0, 3'd5, 16'sd1,    16'd10,    1'b0, 48'sd0, 12'd0},
    '{STEP_CFG,  REG_ROW_LENGTH, 13'd8,    3'd0, 16'sd0,    16'd0,     1'b0, 48'sd0, 12'd0},
    '{STEP_CFG,  REG_GROUP_SIZE, 13'd4,    3'd0, 16'sd0,    16'd0,     1'b0, 48'sd0, 12'd0},
    '{STEP_ELEM, 2'd0, 13'd0, 3'd2, -16'sd500, 16'd4000,  1'b0, 48'sd0, 12'd0},
    '{STEP_ELEM, 2'd0, 13'd0, 3'd6, 16'sd123,  16'd77,    1'b0, 48'sd0, 12'd0},
    '{STEP_ELEM, 2'd0, 13'd0, 3'd0, -16'sd7,   16'hffff,  1'b0, 48'sd0, 12'd0},
    '{STEP_CFG,  REG_ROW_LENGTH, 13'd2,    3'd0, 16'sd0,    16'd0,     1'b0, 48'sd0, 12'd0},
    '{STEP_CFG,  REG_GROUP_SIZE, 13'd2,    3'd0, 16'sd0,    16'd0,     1'b0, 48'sd0, 12'd0},
    '{STEP_ELEM, 2'd0, 13'd0, 3'd7, 16'sh7fff, 16'd4095,  1'b0, 48'sd0, 12'd0},
    '{STEP_CFG,  REG_GROUP_SIZE, 13'd0,    3'd0, 16'sd0,    16'd0,     1'b0, 48'sd0, 12'd0},
    '{STEP_ELEM, 2'd0, 13'd0, 3'd3, 16'sh8000, 16'hffff,  1'b0, 48'sd0, 12'd0}
  };

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_we;
  logic [1:0]              cfg_index;
  logic [CFG_W-1:0]        cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic [CODE_W-1:0]       weight_code;
  logic signed [ACT_W-1:0] activation;
  logic [SCL_W-1:0]        scale;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [ACC_W-1:0] row_result;
  logic [IDX_W-1:0]        row_number;

  int unsigned m_row_length;
  int unsigned m_group_size;
  int unsigned m_row_count;
  longint      m_acc;
  int unsigned m_eidx;
  int unsigned m_gpos;
  int unsigned m_held;
  int unsigned m_row;

  row_sum_t   exp_q[$];
  row_sum_t   exp_item;
  int         errors      = 0;
  int         idle_cycles = 0;
  int         burst_left;
  int         hold_reqs;
  sink_mode_t sink_mode;

  int3_dequant_dot_product_unit dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .weight_code, .activation, .scale,
    .out_valid, .out_ready, .row_result, .row_number
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  function automatic int unsigned clamp_val(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void model_reset();
    m_row_length = 32'(ROW_LENGTH_RST);
    m_group_size = 32'(GROUP_SIZE_RST);
    m_row_count  = 32'(ROW_COUNT_RST);
    m_acc        = 0;
    m_eidx       = 0;
    m_gpos       = 0;
    m_held       = 0;
    m_row        = 0;
  endfunction

  function automatic void model_config(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    case (idx)
      REG_ROW_LENGTH: m_row_length = 32'(data);
      REG_GROUP_SIZE: m_group_size = 32'(data);
      REG_ROW_COUNT:  m_row_count  = 32'(data);
      default: ;
    endcase
  endfunction

  function automatic bit model_step(input logic [CODE_W-1:0] code,
                                    input logic signed [ACT_W-1:0] act,
                                    input logic [SCL_W-1:0] scl,
                                    output row_sum_t res);
    int unsigned len;
    int unsigned gsz;
    int unsigned rows;
    longint      level;
    longint      prod;
    longint      total;
    len   = clamp_val(m_row_length, MAX_ROW_LENGTH);
    gsz   = clamp_val(m_group_size, MAX_ROW_LENGTH);
    rows  = clamp_val(m_row_count, MAX_ROWS);
    level = longint'(code) - longint'(LEVEL_OFFSET);
    if (m_gpos == 0 || m_gpos >= gsz) begin
      m_held = 32'(scl);
      m_gpos = 0;
    end
    prod  = level * longint'(m_held) * longint'(act);
    total = m_acc + prod;
    if (total > ACC_TOP) total = ACC_TOP;
    if (total < -ACC_TOP - 1) total = -ACC_TOP - 1;
    m_acc = total;
    m_gpos++;
    if (m_gpos >= gsz) m_gpos = 0;
    res = '0;
    if (m_eidx + 1 >= len) begin
      res.sum = ACC_W'(m_acc);
      res.row = IDX_W'(m_row);
      m_acc   = 0;
      m_eidx  = 0;
      m_gpos  = 0;
      if (m_row + 1 >= rows) begin
        m_row = 0;
      end else begin
        m_row++;
      end
      return 1'b1;
    end
    m_eidx++;
    return 1'b0;
  endfunction

  task automatic send_elem(input logic [CODE_W-1:0] code,
                           input logic signed [ACT_W-1:0] act,
                           input logic [SCL_W-1:0] scl,
                           input logic known,
                           input logic signed [ACC_W-1:0] sum,
                           input logic [IDX_W-1:0] row);
    row_sum_t res;
    bit       has_res;
    int       gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 4);
      burst_left = $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    burst_left--;
    has_res = model_step(code, act, scl, res);
    if (known) begin
      res.sum = sum;
      res.row = row;
      exp_q.push_back(res);
    end else if (has_res) begin
      exp_q.push_back(res);
    end
    @(negedge clk);
    in_valid    = 1'b1;
    weight_code = code;
    activation  = act;
    scale       = scl;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    in_valid = 1'b0;
    while (exp_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    model_config(idx, data);
    burst_left = 0;
  endtask

  function automatic logic [CFG_W-1:0] pick_cfg(input int unsigned typical_hi);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return CFG_W'($urandom_range(1, typical_hi));
  endfunction

  task automatic send_random();
    logic [CODE_W-1:0]       code;
    logic signed [ACT_W-1:0] act;
    logic [SCL_W-1:0]        scl;
    code = CODE_W'($urandom_range(0, 7));
    act  = ACT_W'($urandom);
    scl  = SCL_W'($urandom);
    if ($urandom_range(0, 9) == 0) act = {1'b1, {(ACT_W-1){1'b0}}};
    if ($urandom_range(0, 9) == 0) scl = '1;
    send_elem(code, act, scl, 1'b0, '0, '0);
  endtask

  task automatic finish_run();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  endtask

  initial begin : stim
    int    n;
    int    ph;
    step_t st;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    weight_code = '0;
    activation  = '0;
    scale       = '0;
    burst_left  = 0;
    hold_reqs   = 0;
    sink_mode   = SINK_OPEN;
    model_reset();
    repeat (12) @(negedge clk);
    rst = 1'b0;
    for (n = 0; n < PLAN_LEN; n++) begin
      st = PLAN[n];
      if (st.kind == STEP_CFG) begin
        write_cfg(st.idx, st.data);
      end else begin
        send_elem(st.code, st.act, st.scl, st.known, st.sum, st.row);
      end
    end
    for (ph = 0; ph < PHASES; ph++) begin
      write_cfg(REG_ROW_LENGTH, pick_cfg(12));
      write_cfg(REG_GROUP_SIZE, pick_cfg(6));
      write_cfg(REG_ROW_COUNT, pick_cfg(5));
      sink_mode = sink_mode_t'(ph % 4);
      if (ph == PRESSURE_PHASE) begin
        write_cfg(REG_ROW_LENGTH, CFG_W'(1));
        hold_reqs++;
      end
      for (n = 0; n < PHASE_ELEMS; n++) send_random();
    end
    @(negedge clk);
    in_valid = 1'b0;
    while (exp_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    finish_run();
  end

  initial begin : sink
    int held;
    int ticks;
    int done_reqs;
    ticks     = 0;
    done_reqs = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      ticks++;
      if (done_reqs != hold_reqs) begin
        done_reqs = hold_reqs;
        out_ready = 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
      end
      case (sink_mode)
        SINK_OPEN:        out_ready = 1'b1;
        SINK_HALF:        out_ready = 1'($urandom_range(0, 1));
        SINK_SPARSE:      out_ready = ($urandom_range(0, 3) == 0);
        SINK_EVERY_THIRD: out_ready = ((ticks % 3) == 0);
        default:          out_ready = 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (exp_q.size() == 0) begin
        report($sformatf("unexpected row result %0d for row %0d", row_result, row_number));
      end else begin
        exp_item = exp_q.pop_front();
        if (row_result !== exp_item.sum || row_number !== exp_item.row) begin
          report($sformatf("row %0d sum %0d, expected row %0d sum %0d",
                           row_number, row_result, exp_item.row, exp_item.sum));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      report("no transfer within the cycle limit");
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
